// ===== sv/cts_pkg.sv =====
// Shared constants for the cosine series evaluator.
package cts_pkg;

    // Item fields
    localparam int ANGLE_W   = 31;
    localparam int COS_W     = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Series length: terms up to x^MAX_POWER
    localparam int MAX_POWER = 40;
    localparam int NUM_TERMS = MAX_POWER / 2;

    // Fixed-point formats
    localparam int AX_W       = 30;   // |x|, unsigned Q3.27
    localparam int SQ_W       = 59;   // x^2, unsigned Q5.54
    localparam int TERM_W     = 60;   // term, unsigned Q4.56
    localparam int SUM_W      = 62;   // running sum, signed Q6.56
    localparam int TERM_FRAC  = 56;
    localparam int SQ_FRAC    = 54;
    localparam int RECIP_FRAC = 62;
    localparam int COS_FRAC   = 30;

    // Multiplier operand B: recip (Q0.62) or x^2 aligned to 62 fraction bits
    localparam int MUL_B_W   = SQ_W + (RECIP_FRAC - SQ_FRAC);
    localparam int SPLIT_W   = 32;
    localparam int A_HI_W    = TERM_W - SPLIT_W;
    localparam int B_HI_W    = MUL_B_W - SPLIT_W;
    localparam int PROD_W    = TERM_W + MUL_B_W;
    localparam int MID_W     = SPLIT_W + B_HI_W + 1;
    localparam int MUL_STAGES = 3;
    localparam int ITER_STAGES = 2 * MUL_STAGES;

    // Limits
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = ANGLE_W'(536870912);
    localparam int RND_SHIFT = TERM_FRAC - COS_FRAC;
    localparam int RES_W     = SUM_W + 1 - RND_SHIFT;
    localparam logic signed [RES_W-1:0] OUT_ONE = RES_W'(64'sd1073741824);

endpackage

// ===== sv/cts_mul.sv =====
// Three-stage unsigned multiply with round-to-nearest and fixed right shift.
module cts_mul
    import cts_pkg::*;
(
    input  logic               aclk,
    input  logic               ce,
    input  logic [TERM_W-1:0]  a,
    input  logic [MUL_B_W-1:0] b,
    output logic [TERM_W-1:0]  p
);

    localparam logic [2*SPLIT_W:0] RND_ADD = (2*SPLIT_W+1)'(1) << (RECIP_FRAC - 1);

    logic [SPLIT_W-1:0]          al, bl;
    logic [A_HI_W-1:0]           ah;
    logic [B_HI_W-1:0]           bh;
    logic [2*SPLIT_W-1:0]        ll_next, ll_reg;
    logic [SPLIT_W+B_HI_W-1:0]   lh_next, lh_reg;
    logic [A_HI_W+SPLIT_W-1:0]   hl_next, hl_reg;
    logic [A_HI_W+B_HI_W-1:0]    hh_next, hh_reg, hh2_reg;
    logic [MID_W-1:0]            mid_next, mid_reg;
    logic [2*SPLIT_W:0]          lo_next, lo_reg;
    logic [PROD_W-1:0]           hh_ext, mid_ext, lo_ext, full;
    logic [TERM_W-1:0]           p_reg;

    // Stage 1: four partial products
    assign al = a[SPLIT_W-1:0];
    assign ah = a[TERM_W-1:SPLIT_W];
    assign bl = b[SPLIT_W-1:0];
    assign bh = b[MUL_B_W-1:SPLIT_W];
    assign ll_next = al * bl;
    assign lh_next = al * bh;
    assign hl_next = ah * bl;
    assign hh_next = ah * bh;

    // Stage 2: combine cross products, add rounding bias to the low part
    assign mid_next = lh_reg + hl_reg;
    assign lo_next  = {1'b0, ll_reg} + RND_ADD;

    // Stage 3: full product and shift
    assign hh_ext  = {hh2_reg, {(2*SPLIT_W){1'b0}}};
    assign mid_ext = PROD_W'(mid_reg) << SPLIT_W;
    assign lo_ext  = PROD_W'(lo_reg);
    assign full    = hh_ext + mid_ext + lo_ext;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            hl_reg  <= hl_next;
            hh_reg  <= hh_next;
            mid_reg <= mid_next;
            lo_reg  <= lo_next;
            hh2_reg <= hh_reg;
            p_reg   <= full[RECIP_FRAC +: TERM_W];
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/cosine_taylor_series.sv =====
// Cosine by a truncated Maclaurin series, fully pipelined.
//
// Usage:
//   s_tdata[30:0] carries the angle, signed Q4.27 radians; angles beyond
//   plus or minus 4 are clamped to magnitude 4. m_tdata[31:0] carries the
//   cosine, signed Q1.30, clamped to plus or minus 1. One result per input
//   item, in order.
//   Throughput: one item per cycle unless the pipeline is stalled. Each
//   series term takes six stages (two split 60x67-bit multipliers of three
//   stages each); the 20 terms set the depth.
//   Stall: a finished item waits in the output register; the pipeline keeps
//   moving and taking items while its last stage is empty, and freezes only
//   when the last stage holds an item that cannot enter the output register.
//   s_tready then drops in the same cycle.
//   Reset: aresetn clears every valid bit; nothing is in flight afterwards.
module cosine_taylor_series
    import cts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] angle
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] cosine
);

    localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << TERM_FRAC;
    localparam bit FINAL_SUB = (NUM_TERMS % 2) == 1;

    logic ce;

    // Front stages
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] angle_neg;
    logic [AX_W-1:0]           ax_next, ax_reg;
    logic [2*AX_W-1:0]         sq_full;
    logic [SQ_W-1:0]           sq_reg;
    logic                      v_ax_reg, v_sq_reg;

    // Iteration boundaries
    logic [TERM_W-1:0]        term_in [NUM_TERMS+1];
    logic [SQ_W-1:0]          sq_in   [NUM_TERMS+1];
    logic signed [SUM_W-1:0]  sum_in  [NUM_TERMS+1];
    logic                     v_in    [NUM_TERMS+1];

    // Back stages
    logic signed [SUM_W-1:0]  fin_next, fin_reg;
    logic                     v_fin_reg;
    logic signed [SUM_W:0]    biased;
    logic signed [RES_W-1:0]  rnd;
    logic signed [COS_W-1:0]  res_next, res_reg, cos_reg;
    logic                     v_res_reg, m_tvalid_reg;

    // Pipeline advances unless the last stage's item is blocked
    assign ce       = m_tready || !m_tvalid_reg || !v_res_reg;
    assign s_tready = ce;

    // Clamp and magnitude of the angle
    assign angle     = signed'(s_tdata[ANGLE_W-1:0]);
    assign angle_neg = -angle;
    always_comb begin
        priority if (angle > ANGLE_LIMIT) begin
            ax_next = ANGLE_LIMIT[AX_W-1:0];
        end else if (angle < -ANGLE_LIMIT) begin
            ax_next = ANGLE_LIMIT[AX_W-1:0];
        end else if (angle < 0) begin
            ax_next = angle_neg[AX_W-1:0];
        end else begin
            ax_next = angle[AX_W-1:0];
        end
    end

    assign sq_full = ax_reg * ax_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax_reg <= ax_next;
            sq_reg <= sq_full[SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_ax_reg <= 1'b0;
            v_sq_reg <= 1'b0;
        end else if (ce) begin
            v_ax_reg <= s_tvalid;
            v_sq_reg <= v_ax_reg;
        end
    end

    // Series starts at 1 with an empty sum
    assign term_in[0] = TERM_ONE;
    assign sq_in[0]   = sq_reg;
    assign sum_in[0]  = '0;
    assign v_in[0]    = v_sq_reg;

    // One iteration per term: fold in the incoming term, build the next one
    for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
        localparam logic [MUL_B_W-1:0] DEN   = MUL_B_W'((2*k + 1) * (2*k + 2));
        localparam logic [MUL_B_W-1:0] RECIP =
            ((MUL_B_W'(1) << RECIP_FRAC) + DEN / 2) / DEN;
        localparam bit SUBTRACT = (k % 2) == 1;

        logic [SQ_W-1:0]         sq_d_reg  [ITER_STAGES];
        logic signed [SUM_W-1:0] sum_d_reg [ITER_STAGES];
        logic [ITER_STAGES-1:0]  v_d_reg;
        logic signed [SUM_W-1:0] sum_next;
        logic [TERM_W-1:0]       t1;
        logic [MUL_B_W-1:0]      sq_b;

        if (SUBTRACT) begin : g_sub
            assign sum_next = sum_in[k] - signed'(SUM_W'(term_in[k]));
        end else begin : g_add
            assign sum_next = sum_in[k] + signed'(SUM_W'(term_in[k]));
        end

        // Side delay lines that follow the two multipliers
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_d_reg[0]  <= sq_in[k];
                sum_d_reg[0] <= sum_next;
                for (int j = 1; j < ITER_STAGES; j++) begin
                    sq_d_reg[j]  <= sq_d_reg[j-1];
                    sum_d_reg[j] <= sum_d_reg[j-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_d_reg <= '0;
            end else if (ce) begin
                v_d_reg <= {v_d_reg[ITER_STAGES-2:0], v_in[k]};
            end
        end

        // term / ((i-1)*i), then times x^2
        cts_mul u_mul_recip (
            .aclk (aclk),
            .ce   (ce),
            .a    (term_in[k]),
            .b    (RECIP),
            .p    (t1)
        );

        assign sq_b = {sq_d_reg[MUL_STAGES-1], {(RECIP_FRAC - SQ_FRAC){1'b0}}};

        cts_mul u_mul_sq (
            .aclk (aclk),
            .ce   (ce),
            .a    (t1),
            .b    (sq_b),
            .p    (term_in[k+1])
        );

        assign sq_in[k+1]  = sq_d_reg[ITER_STAGES-1];
        assign sum_in[k+1] = sum_d_reg[ITER_STAGES-1];
        assign v_in[k+1]   = v_d_reg[ITER_STAGES-1];
    end

    // Fold in the last term
    if (FINAL_SUB) begin : g_fin_sub
        assign fin_next = sum_in[NUM_TERMS] - signed'(SUM_W'(term_in[NUM_TERMS]));
    end else begin : g_fin_add
        assign fin_next = sum_in[NUM_TERMS] + signed'(SUM_W'(term_in[NUM_TERMS]));
    end

    // Round half up to Q1.30 and clamp; sign-extend the sum before the bias
    assign biased = {fin_reg[SUM_W-1], fin_reg} + ((SUM_W+1)'(1) << (RND_SHIFT - 1));
    assign rnd    = biased[SUM_W:RND_SHIFT];
    always_comb begin
        priority if (rnd > OUT_ONE) begin
            res_next = OUT_ONE[COS_W-1:0];
        end else if (rnd < -OUT_ONE) begin
            res_next = -OUT_ONE[COS_W-1:0];
        end else begin
            res_next = rnd[COS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fin_reg <= fin_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_fin_reg <= 1'b0;
            v_res_reg <= 1'b0;
        end else if (ce) begin
            v_fin_reg <= v_in[NUM_TERMS];
            v_res_reg <= v_fin_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (m_tready || !m_tvalid_reg) begin
            m_tvalid_reg <= v_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_tvalid_reg) begin
            cos_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cos_reg;

endmodule
